[rtl/sv39m_pkg.sv]
`default_nettype none

package sv39m_pkg;

	localparam int ENTRY_W = 64;
	localparam int PPN_W = 44;
	localparam int VPN_W = 9;
	localparam int PAGE_OFS_W = 12;
	localparam int VA_BITS = 39;
	localparam int COUNT_W = 28;

	localparam logic [63:0] PAGE_BYTES = 64'd4096;
	localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

	localparam logic REG_POOL_BASE = 1'b0;

	localparam logic [1:0] LVL_ROOT = 2'd2;
	localparam logic [1:0] LVL_MID = 2'd1;
	localparam logic [1:0] LVL_LEAF = 2'd0;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_VA_RANGE = 3'd2,
		ST_POOL_FULL = 3'd3,
		ST_REMAP = 3'd4
	} status_t;

	typedef struct packed {
		logic [63:0] virtual_address;
		logic [55:0] physical_address;
		logic [39:0] region_size;
		logic [7:0] permissions;
	} map_req_t;

	typedef struct packed {
		status_t status;
		logic [COUNT_W-1:0] pages_mapped;
	} map_rsp_t;

	typedef struct packed {
		logic [63:0] op_a;
		logic [63:0] op_b;
		logic sub;
	} alu_req_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LAST,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_FOREIGN,
		S_ZERO,
		S_LINK,
		S_ADV_A,
		S_ADV_P,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/sv39m_alu.sv]
`default_nettype none

module sv39m_alu (
	input  wire sv39m_pkg::alu_req_t alu_req,
	output logic [63:0]             alu_y
);
	import sv39m_pkg::*;

	always_comb begin
		if (alu_req.sub) begin
			alu_y = alu_req.op_a - alu_req.op_b;
		end else begin
			alu_y = alu_req.op_a + alu_req.op_b;
		end
	end

endmodule

`default_nettype wire

[rtl/sv39m_store.sv]
`default_nettype none

module sv39m_store #(
	parameter int POOL_PAGES = 64,
	localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1,
	localparam int ADDR_W = PAGE_W + 9
) (
	input  wire                             clk,
	input  wire                             we,
	input  wire                             re,
	input  wire  [ADDR_W-1:0]               addr,
	input  wire  [sv39m_pkg::ENTRY_W-1:0]   wdata,
	output logic [sv39m_pkg::ENTRY_W-1:0]   rdata
);
	import sv39m_pkg::*;

	localparam int DEPTH = POOL_PAGES * 512;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/sv39m_cfg.sv]
`default_nettype none

module sv39m_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [3:0]                    paddr,
	input  wire  [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	output logic [sv39m_pkg::PPN_W-1:0]   pool_base
);
	import sv39m_pkg::*;

	logic [PPN_W-1:0] pool_base_q;
	logic             wr_en;

	assign wr_en = psel && penable && pwrite && (paddr[3] == REG_POOL_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= POOL_BASE_RESET;
		end else if (wr_en) begin
			pool_base_q <= pwdata[PPN_W-1:0];
		end
	end

	always_comb begin
		if (paddr[3] == REG_POOL_BASE) begin
			prdata = {{(64-PPN_W){1'b0}}, pool_base_q};
		end else begin
			prdata = '0;
		end
	end

	assign pready = 1'b1;
	assign pool_base = pool_base_q;

endmodule

`default_nettype wire

[rtl/sv39m_ctrl.sv]
`default_nettype none

module sv39m_ctrl #(
	parameter int POOL_PAGES = 64,
	localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1,
	localparam int ADDR_W = PAGE_W + 9
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  sv39m_pkg::map_req_t       req,
	output logic                            done,
	output sv39m_pkg::map_rsp_t             rsp,
	input  wire  [sv39m_pkg::PPN_W-1:0]     pool_base,
	output logic                            mem_we,
	output logic                            mem_re,
	output logic [ADDR_W-1:0]               mem_addr,
	output logic [sv39m_pkg::ENTRY_W-1:0]   mem_wdata,
	input  wire  [sv39m_pkg::ENTRY_W-1:0]   mem_rdata,
	output sv39m_pkg::alu_req_t             alu_req,
	input  wire  [63:0]                     alu_y
);
	import sv39m_pkg::*;

	localparam int DEPTH = POOL_PAGES * 512;
	localparam int NF_W = $clog2(POOL_PAGES + 1);

	state_t state_q, state_d;

	logic [NF_W-1:0]    nf_q;
	logic [ADDR_W-1:0]  clr_q;

	logic [63:0]        a_q;
	logic [63:0]        last_q;
	logic [63:0]        tmp_q;
	logic [PPN_W-1:0]   ppn_q;
	logic [7:0]         perm_q;
	logic [COUNT_W-1:0] count_q;
	status_t            status_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PAGE_W-1:0]  np_q;
	logic [1:0]         level_q;
	logic [ADDR_W-1:0]  slot_q;

	logic [VPN_W-1:0]   vpn_sel;
	logic               e_valid;
	logic               is_leaf;
	logic               pool_full;
	logic               foreign_bad;
	logic               misaligned;
	logic               va_bad;
	logic               at_last;

	assign e_valid = mem_rdata[0];
	assign is_leaf = (level_q == LVL_LEAF);
	assign pool_full = (nf_q >= NF_W'(POOL_PAGES));
	assign foreign_bad = (tmp_q[PPN_W-1:0] >= PPN_W'(POOL_PAGES));
	assign misaligned = (req.physical_address[PAGE_OFS_W-1:0] != '0);
	assign va_bad = (a_q[63:VA_BITS] != '0);
	assign at_last = (a_q == last_q);

	always_comb begin
		unique case (level_q)
			LVL_ROOT: vpn_sel = a_q[38:30];
			LVL_MID:  vpn_sel = a_q[29:21];
			default:  vpn_sel = a_q[20:12];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = misaligned ? S_DONE : S_LAST;
			end
			S_LAST:  state_d = S_CHECK;
			S_CHECK: state_d = va_bad ? S_DONE : S_READ;
			S_READ:  state_d = S_EVAL;
			S_EVAL: begin
				if (is_leaf) begin
					if (e_valid || at_last) state_d = S_DONE;
					else state_d = S_ADV_A;
				end else if (e_valid) begin
					state_d = S_FOREIGN;
				end else if (pool_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_FOREIGN: state_d = foreign_bad ? S_DONE : S_READ;
			S_ZERO: begin
				if (clr_q[8:0] == 9'h1FF) state_d = S_LINK;
			end
			S_LINK:  state_d = S_READ;
			S_ADV_A: state_d = S_ADV_P;
			S_ADV_P: state_d = S_CHECK;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = slot_q;
		mem_wdata = '0;
		alu_req = '{op_a: a_q, op_b: PAGE_BYTES, sub: 1'b0};
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				alu_req = '{op_a: req.virtual_address,
					op_b: {24'b0, req.region_size}, sub: 1'b0};
			end
			S_LAST: begin
				alu_req = '{op_a: tmp_q, op_b: 64'd1, sub: 1'b1};
			end
			S_READ: begin
				mem_re = 1'b1;
				mem_addr = {page_q, vpn_sel};
			end
			S_EVAL: begin
				mem_we = is_leaf && !e_valid;
				mem_wdata = {10'b0, ppn_q, 2'b00, perm_q[7:1], 1'b1};
				alu_req = '{op_a: {20'b0, mem_rdata[53:10]},
					op_b: {20'b0, pool_base}, sub: 1'b1};
			end
			S_ZERO: begin
				mem_we = 1'b1;
				mem_addr = {np_q, clr_q[8:0]};
			end
			S_LINK: begin
				mem_we = 1'b1;
				mem_wdata = {10'b0, alu_y[PPN_W-1:0], 9'b0, 1'b1};
				alu_req = '{op_a: {{(64-PAGE_W){1'b0}}, np_q},
					op_b: {20'b0, pool_base}, sub: 1'b0};
			end
			S_ADV_P: begin
				alu_req = '{op_a: {20'b0, ppn_q}, op_b: 64'd1, sub: 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp = '{status: status_q, pages_mapped: count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			nf_q <= NF_W'(1);
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR || state_q == S_ZERO) begin
				clr_q <= clr_q + ADDR_W'(1);
			end else if (state_q == S_EVAL) begin
				clr_q <= '0;
			end
			if (state_q == S_EVAL && !is_leaf && !e_valid && !pool_full) begin
				nf_q <= nf_q + NF_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					a_q <= {req.virtual_address[63:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
					tmp_q <= alu_y;
					ppn_q <= req.physical_address[55:PAGE_OFS_W];
					perm_q <= req.permissions;
					count_q <= '0;
					status_q <= misaligned ? ST_MISALIGNED : ST_OK;
				end
			end
			S_LAST: begin
				last_q <= {alu_y[63:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
			end
			S_CHECK: begin
				page_q <= '0;
				level_q <= LVL_ROOT;
				if (va_bad) status_q <= ST_VA_RANGE;
			end
			S_READ: begin
				slot_q <= mem_addr;
			end
			S_EVAL: begin
				if (is_leaf) begin
					if (e_valid) status_q <= ST_REMAP;
					else count_q <= count_q + COUNT_W'(1);
				end else if (e_valid) begin
					tmp_q <= alu_y;
				end else if (pool_full) begin
					status_q <= ST_POOL_FULL;
				end else begin
					np_q <= nf_q[PAGE_W-1:0];
				end
			end
			S_FOREIGN: begin
				if (foreign_bad) begin
					status_q <= ST_POOL_FULL;
				end else begin
					page_q <= tmp_q[PAGE_W-1:0];
					level_q <= level_q - 2'd1;
				end
			end
			S_LINK: begin
				page_q <= np_q;
				level_q <= level_q - 2'd1;
			end
			S_ADV_A: begin
				a_q <= alu_y;
			end
			S_ADV_P: begin
				ppn_q <= alu_y[PPN_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/sv39_page_table_mapper.sv]
// channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------
// request  | start, busy (taken on !busy)  | req  (va, pa, size, permissions)
// result   | done, one-cycle strobe        | rsp  (status, pages_mapped)
// config   | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// after reset the table store is swept to zero, with busy high
// a request through existing tables keeps busy high while it walks, paced
// by the one shared 64-bit adder and the single store port
// each new table page is swept clean and then linked
// a misaligned physical address answers in the cycle after the request
// the result strobe lasts one cycle and cannot be held off
`default_nettype none

module sv39_page_table_mapper #(
	parameter int POOL_PAGES = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire  sv39m_pkg::map_req_t  req,
	output logic                       done,
	output sv39m_pkg::map_rsp_t        rsp,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire  [3:0]                 paddr,
	input  wire  [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);
	import sv39m_pkg::*;

	localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int ADDR_W = PAGE_W + 9;

	logic [PPN_W-1:0]   pool_base;
	logic               mem_we;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;
	alu_req_t           alu_req;
	logic [63:0]        alu_y;

	sv39m_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pool_base (pool_base)
	);

	sv39m_alu u_alu (
		.alu_req (alu_req),
		.alu_y   (alu_y)
	);

	sv39m_store #(
		.POOL_PAGES (POOL_PAGES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	sv39m_ctrl #(
		.POOL_PAGES (POOL_PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.pool_base (pool_base),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.alu_req   (alu_req),
		.alu_y     (alu_y)
	);

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import sv39m_pkg::*;

	localparam int POOL_PAGES = 64;
	localparam int ENTRIES = 512;
	localparam int QUIET_CYCLES = 32;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SPARE_REG = 1;
	localparam logic [63:0] VA_TOP = 64'd1 << VA_BITS;

	class mapper_scoreboard;
		logic [ENTRY_W-1:0] table_mem [POOL_PAGES*ENTRIES];
		int unsigned next_free;
		logic [PPN_W-1:0] pool_base;
		map_rsp_t results_due [$];
		int unsigned errors;
		int unsigned requests;
		int unsigned pages_total;
		int unsigned status_count [5];

		function void clear_all();
			foreach (table_mem[i]) table_mem[i] = '0;
			foreach (status_count[i]) status_count[i] = 0;
			next_free = 1;
			pool_base = POOL_BASE_RESET;
			errors = 0;
			requests = 0;
			pages_total = 0;
		endfunction

		function void write_reg(input int unsigned index, input logic [63:0] value);
			if (index == int'(REG_POOL_BASE)) begin
				pool_base = value[PPN_W-1:0];
			end
		endfunction

		// follow or build one non-leaf level, 0 when the pool cannot serve it
		function bit next_table(input int unsigned tbl, input logic [63:0] va, input int lvl,
				output int unsigned nxt);
			int unsigned slot;
			logic [ENTRY_W-1:0] ent;
			logic [PPN_W-1:0] idx;
			nxt = 0;
			slot = tbl * ENTRIES + va[PAGE_OFS_W + VPN_W*lvl +: VPN_W];
			ent = table_mem[slot];
			if (ent[0]) begin
				idx = ent[10 +: PPN_W] - pool_base;
				if (idx >= POOL_PAGES) return 1'b0;
				nxt = int'(idx);
				return 1'b1;
			end
			if (next_free >= POOL_PAGES) return 1'b0;
			nxt = next_free;
			next_free++;
			for (int i = 0; i < ENTRIES; i++) table_mem[nxt * ENTRIES + i] = '0;
			ent = '0;
			ent[10 +: PPN_W] = PPN_W'(nxt) + pool_base;
			ent[0] = 1'b1;
			table_mem[slot] = ent;
			return 1'b1;
		endfunction

		function map_rsp_t walk_and_map(input map_req_t r);
			map_rsp_t res;
			logic [63:0] a;
			logic [63:0] last_page;
			logic [PPN_W-1:0] ppn;
			int unsigned mid;
			int unsigned leaf;
			int unsigned slot;
			bit running;
			res.status = ST_OK;
			res.pages_mapped = '0;
			mid = 0;
			leaf = 0;
			a = r.virtual_address & ~(PAGE_BYTES - 64'd1);
			last_page = (r.virtual_address + 64'(r.region_size) - 64'd1) & ~(PAGE_BYTES - 64'd1);
			ppn = r.physical_address[PAGE_OFS_W +: PPN_W];
			running = (r.physical_address[PAGE_OFS_W-1:0] == '0);
			if (!running) res.status = ST_MISALIGNED;
			while (running) begin
				if (a >= VA_TOP) begin
					res.status = ST_VA_RANGE;
					running = 1'b0;
				end else if (!next_table(0, a, int'(LVL_ROOT), mid)) begin
					res.status = ST_POOL_FULL;
					running = 1'b0;
				end else if (!next_table(mid, a, int'(LVL_MID), leaf)) begin
					res.status = ST_POOL_FULL;
					running = 1'b0;
				end else begin
					slot = leaf * ENTRIES + a[PAGE_OFS_W +: VPN_W];
					if (table_mem[slot][0]) begin
						res.status = ST_REMAP;
						running = 1'b0;
					end else begin
						table_mem[slot] = {10'b0, ppn, 2'b0, r.permissions} | 64'd1;
						res.pages_mapped = res.pages_mapped + 1'b1;
						if (a == last_page) begin
							running = 1'b0;
						end else begin
							a = a + PAGE_BYTES;
							ppn = ppn + 1'b1;
						end
					end
				end
			end
			return res;
		endfunction

		function void note_request(input map_req_t r);
			results_due.push_back(walk_and_map(r));
			requests++;
		endfunction

		function void check_result(input map_rsp_t got);
			map_rsp_t want;
			if (results_due.size() == 0) begin
				$display("%t result with no request pending: status %0d pages %0d",
					$time, got.status, got.pages_mapped);
				errors++;
				return;
			end
			want = results_due.pop_front();
			status_count[int'(want.status)]++;
			pages_total += want.pages_mapped;
			if (got.status !== want.status) begin
				$display("%t status mismatch: expected %0d actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.pages_mapped !== want.pages_mapped) begin
				$display("%t pages_mapped mismatch: expected %0d actual %0d",
					$time, want.pages_mapped, got.pages_mapped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	map_req_t req;
	logic done;
	map_rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	int unsigned cycle_count = 0;
	int unsigned config_writes = 0;
	mapper_scoreboard board;

	sv39_page_table_mapper #(.POOL_PAGES(POOL_PAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(rsp);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, board.results_due.size());
			$display("[sv39_page_table_mapper] ERROR");
			$finish;
		end
	end

	function automatic map_req_t req_of(input logic [63:0] va, input logic [55:0] pa,
			input logic [39:0] size, input logic [7:0] perm);
		map_req_t r;
		r.virtual_address = va;
		r.physical_address = pa;
		r.region_size = size;
		r.permissions = perm;
		return r;
	endfunction

	// most requests land in a few hot table pages so the walks go deep
	function automatic map_req_t make_map_req(input bit allow_long);
		map_req_t r;
		int unsigned pick;
		logic [VPN_W-1:0] hot_top [4];
		logic [VPN_W-1:0] hot_mid [4];
		hot_top = '{9'd0, 9'd1, 9'd255, 9'd511};
		hot_mid = '{9'd0, 9'd1, 9'd256, 9'd511};
		pick = $urandom_range(99);
		r.virtual_address = {25'b0, hot_top[$urandom_range(3)], hot_mid[$urandom_range(3)],
			9'($urandom), 12'($urandom)};
		if (pick < 3) begin
			r.virtual_address = {25'b0, 39'({$urandom, $urandom})};
		end else if (pick < 6) begin
			r.virtual_address = {$urandom, $urandom};
		end else if (pick < 8) begin
			r.virtual_address[$urandom_range(63, VA_BITS)] = 1'b1;
		end else if (pick < 20) begin
			r.virtual_address[PAGE_OFS_W-1:0] = '0;
		end
		pick = $urandom_range(99);
		r.physical_address = 56'({$urandom, $urandom});
		r.physical_address[PAGE_OFS_W-1:0] = '0;
		if (pick < 5) begin
			r.physical_address[PAGE_OFS_W-1:0] = 12'($urandom_range(1, 4095));
		end else if (pick < 8) begin
			r.physical_address[55:PAGE_OFS_W+4] = '1;
		end
		pick = $urandom_range(99);
		if (allow_long && pick < 2) begin
			r.region_size = 40'({$urandom, $urandom});
		end else if (allow_long && pick < 3) begin
			r.region_size = '0;
		end else if (pick < 70) begin
			r.region_size = 40'($urandom_range(1, 4 * 4096));
		end else if (pick < 90) begin
			r.region_size = 40'($urandom_range(1, 64 * 4096));
		end else begin
			r.region_size = 40'($urandom_range(1, 8) * 4096);
		end
		r.permissions = 8'($urandom);
		return r;
	endfunction

	task automatic send_map(input map_req_t r);
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain();
		while (board.results_due.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_config(input int unsigned index, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(index * 8);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(index, value);
		config_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_pool_base();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'(int'(REG_POOL_BASE) * 8);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 64'(board.pool_base)) begin
			$display("%t pool_base readback mismatch: expected %h actual %h",
				$time, 64'(board.pool_base), prdata);
			board.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_segment(input int unsigned count, input bit allow_long);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(7) == 0) ? 48 : $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_map(make_map_req(allow_long));
				sent++;
			end
			gap = $urandom_range(0, 12);
			if (sent == count || gap != 0) begin
				start <= 1'b0;
				if ($urandom_range(39) == 0) drain();
				else repeat (gap) @(negedge clk);
			end
		end
	endtask

	initial begin
		map_req_t directed [$];
		logic [PPN_W-1:0] base;
		int unsigned items;
		bit allow_long;
		board = new();
		board.clear_all();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// table sweep after reset keeps busy high
		drain();
		write_config(int'(REG_POOL_BASE), {20'($urandom), POOL_BASE_RESET});
		write_config(SPARE_REG, {$urandom, $urandom});
		check_pool_base();

		directed.push_back(req_of(64'h0, 56'h0, 40'd1, 8'h00));
		directed.push_back(req_of(64'h0, 56'h2000, 40'd1, 8'hFF));
		directed.push_back(req_of(64'h3000, 56'h1, 40'd4096, 8'h0F));
		directed.push_back(req_of(64'h3000, '1, 40'd4096, 8'h00));
		directed.push_back(req_of(VA_TOP, 56'h0, 40'd4096, 8'h0F));
		directed.push_back(req_of('1, 56'h0, '1, 8'hFF));
		directed.push_back(req_of(64'h8000_0000_0000_0000, 56'h800, 40'd4096, 8'h01));
		directed.push_back(req_of(VA_TOP - 2 * PAGE_BYTES, 56'h10000, 40'd0, 8'h07));
		directed.push_back(req_of(VA_TOP - 3 * PAGE_BYTES, 56'h20000, 40'(3 * 4096), 8'h03));
		directed.push_back(req_of(64'h1000, 56'hFF_FFFF_FFFF_F000, 40'(3 * 4096), 8'hFF));
		directed.push_back(req_of(64'h5123, 56'h40000, 40'd4096, 8'hCA));
		directed.push_back(req_of(VA_TOP - 5 * PAGE_BYTES, 56'h50000, '1, 8'h55));
		directed.push_back(req_of(64'h1F_F000, 56'h60000, 40'(2 * 4096), 8'h0B));
		directed.push_back(req_of((64'd1 << 30) | (64'd256 << 21), 56'h7000_0000,
			40'(512 * 4096), 8'hC7));
		directed.push_back(req_of(VA_TOP - 64'd1, 56'h0, 40'd1, 8'h01));
		foreach (directed[i]) send_map(directed[i]);
		start <= 1'b0;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin base = POOL_BASE_RESET; items = 450; allow_long = 1'b0; end
				1: begin base = POOL_BASE_RESET; items = 450; allow_long = 1'b1; end
				2: begin base = '0; items = 150; allow_long = 1'b1; end
				3: begin base = '1; items = 150; allow_long = 1'b1; end
				4: begin base = POOL_BASE_RESET + 1'b1; items = 100; allow_long = 1'b1; end
				default: begin base = POOL_BASE_RESET; items = 550; allow_long = 1'b1; end
			endcase
			write_config(int'(REG_POOL_BASE), {20'($urandom), base});
			check_pool_base();
			run_segment(items, allow_long);
			drain();
		end

		$display("%0d map requests, %0d pages mapped, %0d of %0d table pages used, %0d config writes",
			board.requests, board.pages_total, board.next_free, POOL_PAGES, config_writes);
		$display("outcomes: ok %0d, misaligned %0d, va range %0d, pool full %0d, remap %0d",
			board.status_count[0], board.status_count[1], board.status_count[2],
			board.status_count[3], board.status_count[4]);
		if (board.errors == 0) begin
			$display("[sv39_page_table_mapper] OK");
		end else begin
			$display("[sv39_page_table_mapper] ERROR");
		end
		$finish;
	end

endmodule
